>>> hw/rtl/uhid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhid_pkg
// shared types, request codes and descriptor tables of the hid control endpoint
// ----------------------------------------------------------------------------
package uhid_pkg;

    localparam int PACKET_SIZE_DEF   = 32;
    localparam int ROM_DEPTH_DEF     = 256;
    localparam int TABLE_ENTRIES_DEF = 7;
    localparam int BUILT_ENTRIES     = 7;
    localparam int MAX_PKT           = 32;
    localparam int ROM_LEN           = 171;

    localparam logic [2:0] KIND_SETUP  = 3'd0;
    localparam logic [2:0] KIND_IN     = 3'd1;
    localparam logic [2:0] KIND_OUT    = 3'd2;
    localparam logic [2:0] KIND_RESET  = 3'd3;
    localparam logic [2:0] KIND_REPORT = 3'd4;

    localparam logic [2:0] RSP_NONE    = 3'd0;
    localparam logic [2:0] RSP_DATA    = 3'd1;
    localparam logic [2:0] RSP_ZLP     = 3'd2;
    localparam logic [2:0] RSP_STALL   = 3'd3;
    localparam logic [2:0] RSP_REPORT  = 3'd4;
    localparam logic [2:0] RSP_REFUSED = 3'd5;

    localparam logic [7:0] REQ_GET_STATUS   = 8'h00;
    localparam logic [7:0] REQ_HID_GET_REP  = 8'h01;
    localparam logic [7:0] REQ_HID_GET_IDLE = 8'h02;
    localparam logic [7:0] REQ_HID_GET_PROT = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS  = 8'h05;
    localparam logic [7:0] REQ_GET_DESC     = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG   = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG   = 8'h09;
    localparam logic [7:0] REQ_HID_SET_REP  = 8'h09;
    localparam logic [7:0] REQ_HID_SET_IDLE = 8'h0A;
    localparam logic [7:0] REQ_HID_SET_PROT = 8'h0B;

    localparam logic [7:0] RT_STD_OUT   = 8'h00;
    localparam logic [7:0] RT_STD_IN    = 8'h80;
    localparam logic [7:0] RT_CLASS_IN  = 8'hA1;
    localparam logic [7:0] RT_CLASS_OUT = 8'h21;

    localparam logic [15:0] DESC_VALUE [BUILT_ENTRIES] =
        '{16'h0100, 16'h0200, 16'h2100, 16'h2200, 16'h0300, 16'h0301, 16'h0302};
    localparam logic [15:0] DESC_INDEX [BUILT_ENTRIES] =
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409};
    localparam logic [7:0] DESC_START [BUILT_ENTRIES] =
        '{8'd0, 8'd18, 8'd36, 8'd52, 8'd99, 8'd103, 8'd121};
    localparam logic [7:0] DESC_LEN [BUILT_ENTRIES] =
        '{8'd18, 8'd34, 8'd9, 8'd47, 8'd4, 8'd18, 8'd50};

    localparam logic [ROM_LEN*8-1:0] ROM_BITS = {
        144'h12_01_00_02_00_00_00_20_01_00_02_00_00_01_01_02_03_01,
        72'h09_02_22_00_01_01_00_80_32,
        72'h09_04_00_00_01_03_00_00_00,
        72'h09_21_11_01_00_01_22_2F_00,
        56'h07_05_83_03_08_00_0A,
        80'h05_01_09_05_A1_01_09_01_A1_00,
        88'h09_30_09_31_15_00_26_FF_00_75_08,
        88'h95_02_81_02_C0_05_09_19_01_29_02,
        80'h15_00_25_01_75_01_95_02_81_02,
        40'h95_06_81_03_C0,
        32'h04_03_09_04,
        144'h12_03_50_00_2E_00_55_00_50_00_49_00_4E_00_4F_00_56_00,
        144'h32_03_50_00_2E_00_55_00_50_00_49_00_4E_00_4F_00_56_00,
        128'h20_00_41_00_56_00_52_00_20_00_55_00_53_00_42_00,
        128'h20_00_47_00_41_00_4D_00_45_00_50_00_41_00_44_00
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [7:0]  button_bits;
    } evt_word_t;

    typedef struct packed {
        logic [2:0] response;
        logic [7:0] data_byte;
        logic       last_of_run;
        logic [6:0] device_address;
        logic [7:0] active_configuration;
    } res_word_t;

    function automatic logic [7:0] rom_byte(input logic [8:0] a, input logic [7:0] pkt);
        logic [7:0] b;
        b = 8'h00;
        if (a == 9'd7)
        begin
            b = pkt;
        end
        else if (a < 9'(ROM_LEN))
        begin
            b = ROM_BITS[(ROM_LEN - 1 - int'(a)) * 8 +: 8];
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/usb_hid_control_endpoint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_hid_control_endpoint
// hid control endpoint: setup decode, descriptor streaming, report words
//
//   channel  dir  handshake              word
//   evt      in   evt_valid/evt_ready    uhid_pkg::evt_word_t
//   res      out  res_valid/res_ready    uhid_pkg::res_word_t
//
// an event is decoded in the cycle it is taken; immediate replies leave one
// word per cycle unless res stalls; each descriptor byte is a rom read, then
// a load; an in event streams at most 32 bytes before the next event is taken
// the output register frees the input side; a stalled res holds the sequencer
// reset puts control state, not the reply words, to power-on values; the rom needs no clearing
// ----------------------------------------------------------------------------
module usb_hid_control_endpoint #(
    parameter int PACKET_SIZE   = uhid_pkg::PACKET_SIZE_DEF,
    parameter int ROM_DEPTH     = uhid_pkg::ROM_DEPTH_DEF,
    parameter int TABLE_ENTRIES = uhid_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    output logic                evt_ready,
    input  uhid_pkg::evt_word_t evt,
    output logic                res_valid,
    input  logic                res_ready,
    output uhid_pkg::res_word_t res
);

    localparam int AW  = $clog2(ROM_DEPTH);
    localparam int PKT = (PACKET_SIZE < uhid_pkg::MAX_PKT) ? PACKET_SIZE : uhid_pkg::MAX_PKT;
    localparam int NT  = (TABLE_ENTRIES < uhid_pkg::BUILT_ENTRIES) ?
                         TABLE_ENTRIES : uhid_pkg::BUILT_ENTRIES;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_IMM  = 4'b0010,
        S_RD   = 4'b0100,
        S_WR   = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] cfg_reg, cfg_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] idle_reg, idle_next;
    logic [7:0] prot_reg, prot_next;
    logic [7:0] ax_reg, ax_next;
    logic [7:0] ay_reg, ay_next;
    logic [7:0] btn_reg, btn_next;
    logic       xfer_reg, xfer_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] ptr_reg, ptr_next;
    logic       wait_out_reg, wait_out_next;
    logic [2:0] imm_rsp_reg [3];
    logic [2:0] imm_rsp_next [3];
    logic [7:0] imm_byte_reg [3];
    logic [7:0] imm_byte_next [3];
    logic [1:0] imm_cnt_reg, imm_cnt_next;
    logic [1:0] imm_idx_reg, imm_idx_next;
    logic [5:0] bcnt_reg, bcnt_next;
    logic       res_valid_reg, res_valid_next;
    uhid_pkg::res_word_t res_reg, res_next;

    logic       take;
    logic       out_free;
    logic       hit;
    logic [7:0] hit_start;
    logic [7:0] hit_len;
    logic [7:0] req_len;
    logic [7:0] clip_len;
    logic [5:0] pkt_n;
    logic [8:0] ptr_sub;
    logic [AW-1:0] rom_addr;
    logic [7:0] rom_data;

    assign evt_ready = (state_reg == S_IDLE);
    assign take      = evt_valid && evt_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        hit       = 1'b0;
        hit_start = 8'd0;
        hit_len   = 8'd0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (evt.setup_value == uhid_pkg::DESC_VALUE[i] &&
                evt.setup_index == uhid_pkg::DESC_INDEX[i])
            begin
                hit       = 1'b1;
                hit_start = uhid_pkg::DESC_START[i];
                hit_len   = uhid_pkg::DESC_LEN[i];
            end
        end
    end

    assign req_len  = (evt.setup_length > 16'd255) ? 8'd255 : evt.setup_length[7:0];
    assign clip_len = (req_len > hit_len) ? hit_len : req_len;
    assign pkt_n    = (remain_reg < 8'(PKT)) ? remain_reg[5:0] : 6'(PKT);
    assign ptr_sub  = ({1'b0, ptr_reg} >= 9'(ROM_DEPTH)) ?
                      ({1'b0, ptr_reg} - 9'(ROM_DEPTH)) : {1'b0, ptr_reg};
    assign rom_addr = ptr_sub[AW-1:0];

    uhid_rom #(
        .ROM_DEPTH   (ROM_DEPTH),
        .PACKET_SIZE (PACKET_SIZE)
    ) u_rom (
        .clk     (clk),
        .rd_en   (state_reg == S_RD),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_reg;
        addr_next      = addr_reg;
        idle_next      = idle_reg;
        prot_next      = prot_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        btn_next       = btn_reg;
        xfer_next      = xfer_reg;
        remain_next    = remain_reg;
        ptr_next       = ptr_reg;
        wait_out_next  = wait_out_reg;
        imm_rsp_next   = imm_rsp_reg;
        imm_byte_next  = imm_byte_reg;
        imm_cnt_next   = imm_cnt_reg;
        imm_idx_next   = imm_idx_reg;
        bcnt_next      = bcnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    imm_rsp_next  = '{uhid_pkg::RSP_NONE, uhid_pkg::RSP_NONE,
                                      uhid_pkg::RSP_NONE};
                    imm_byte_next = '{8'd0, 8'd0, 8'd0};
                    imm_cnt_next  = 2'd1;
                    imm_idx_next  = 2'd0;
                    state_next    = S_IMM;
                    case (evt.kind)
                        uhid_pkg::KIND_SETUP:
                        begin
                            xfer_next     = 1'b0;
                            wait_out_next = 1'b0;
                            imm_rsp_next[0] = uhid_pkg::RSP_STALL;
                            if (evt.request_code == uhid_pkg::REQ_GET_DESC)
                            begin
                                if (hit)
                                begin
                                    ptr_next        = hit_start;
                                    remain_next     = clip_len;
                                    xfer_next       = 1'b1;
                                    imm_rsp_next[0] = uhid_pkg::RSP_NONE;
                                end
                            end
                            else if (evt.request_code == uhid_pkg::REQ_SET_ADDRESS)
                            begin
                                addr_next       = evt.setup_value[6:0];
                                imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                            end
                            else if (evt.request_code == uhid_pkg::REQ_SET_CONFIG &&
                                     evt.request_type == uhid_pkg::RT_STD_OUT)
                            begin
                                cfg_next        = evt.setup_value[7:0];
                                imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                            end
                            else if (evt.request_code == uhid_pkg::REQ_GET_CONFIG &&
                                     evt.request_type == uhid_pkg::RT_STD_IN)
                            begin
                                imm_rsp_next[0]  = uhid_pkg::RSP_DATA;
                                imm_byte_next[0] = cfg_reg;
                            end
                            else if (evt.request_code == uhid_pkg::REQ_GET_STATUS)
                            begin
                                imm_rsp_next[0] = uhid_pkg::RSP_DATA;
                                imm_rsp_next[1] = uhid_pkg::RSP_DATA;
                                imm_cnt_next    = 2'd2;
                            end
                            else if (evt.setup_index == 16'd0 &&
                                     evt.request_type == uhid_pkg::RT_CLASS_IN)
                            begin
                                if (evt.request_code == uhid_pkg::REQ_HID_GET_REP)
                                begin
                                    imm_rsp_next  = '{uhid_pkg::RSP_DATA, uhid_pkg::RSP_DATA,
                                                      uhid_pkg::RSP_DATA};
                                    imm_byte_next = '{ax_reg, ay_reg, btn_reg};
                                    imm_cnt_next  = 2'd3;
                                end
                                else if (evt.request_code == uhid_pkg::REQ_HID_GET_IDLE)
                                begin
                                    imm_rsp_next[0]  = uhid_pkg::RSP_DATA;
                                    imm_byte_next[0] = idle_reg;
                                end
                                else if (evt.request_code == uhid_pkg::REQ_HID_GET_PROT)
                                begin
                                    imm_rsp_next[0]  = uhid_pkg::RSP_DATA;
                                    imm_byte_next[0] = prot_reg;
                                end
                            end
                            else if (evt.setup_index == 16'd0 &&
                                     evt.request_type == uhid_pkg::RT_CLASS_OUT)
                            begin
                                if (evt.request_code == uhid_pkg::REQ_HID_SET_REP)
                                begin
                                    wait_out_next   = 1'b1;
                                    imm_rsp_next[0] = uhid_pkg::RSP_NONE;
                                end
                                else if (evt.request_code == uhid_pkg::REQ_HID_SET_IDLE)
                                begin
                                    idle_next       = evt.setup_value[15:8];
                                    imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                                end
                                else if (evt.request_code == uhid_pkg::REQ_HID_SET_PROT)
                                begin
                                    prot_next       = evt.setup_value[7:0];
                                    imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                                end
                            end
                        end
                        uhid_pkg::KIND_IN:
                        begin
                            if (xfer_reg)
                            begin
                                remain_next = remain_reg - 8'(pkt_n);
                                if (remain_reg == 8'(pkt_n) && pkt_n != 6'(PKT))
                                begin
                                    xfer_next = 1'b0;
                                end
                                if (pkt_n == 6'd0)
                                begin
                                    imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                                end
                                else
                                begin
                                    bcnt_next  = pkt_n;
                                    state_next = S_RD;
                                end
                            end
                        end
                        uhid_pkg::KIND_OUT:
                        begin
                            if (xfer_reg)
                            begin
                                xfer_next   = 1'b0;
                                remain_next = 8'd0;
                            end
                            else if (wait_out_reg)
                            begin
                                wait_out_next   = 1'b0;
                                imm_rsp_next[0] = uhid_pkg::RSP_ZLP;
                            end
                        end
                        uhid_pkg::KIND_RESET:
                        begin
                            cfg_next      = 8'd0;
                            addr_next     = 7'd0;
                            xfer_next     = 1'b0;
                            remain_next   = 8'd0;
                            wait_out_next = 1'b0;
                        end
                        uhid_pkg::KIND_REPORT:
                        begin
                            ax_next  = evt.stick_x;
                            ay_next  = evt.stick_y;
                            btn_next = evt.button_bits;
                            if (cfg_reg == 8'd0)
                            begin
                                imm_rsp_next[0] = uhid_pkg::RSP_REFUSED;
                            end
                            else
                            begin
                                imm_rsp_next  = '{uhid_pkg::RSP_REPORT, uhid_pkg::RSP_REPORT,
                                                  uhid_pkg::RSP_REPORT};
                                imm_byte_next = '{evt.stick_x, evt.stick_y, evt.button_bits};
                                imm_cnt_next  = 2'd3;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_IMM:
            begin
                if (out_free)
                begin
                    res_valid_next                = 1'b1;
                    res_next.response             = imm_rsp_reg[imm_idx_reg];
                    res_next.data_byte            = imm_byte_reg[imm_idx_reg];
                    res_next.last_of_run          = (imm_idx_reg == imm_cnt_reg - 2'd1);
                    res_next.device_address       = addr_reg;
                    res_next.active_configuration = cfg_reg;
                    imm_idx_next                  = imm_idx_reg + 2'd1;
                    if (imm_idx_reg == imm_cnt_reg - 2'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    res_valid_next                = 1'b1;
                    res_next.response             = uhid_pkg::RSP_DATA;
                    res_next.data_byte            = rom_data;
                    res_next.last_of_run          = (bcnt_reg == 6'd1);
                    res_next.device_address       = addr_reg;
                    res_next.active_configuration = cfg_reg;
                    ptr_next                      = ptr_reg + 8'd1;
                    bcnt_next                     = bcnt_reg - 6'd1;
                    state_next                    = (bcnt_reg == 6'd1) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= 8'd0;
            addr_reg      <= 7'd0;
            idle_reg      <= 8'd0;
            prot_reg      <= 8'd1;
            ax_reg        <= 8'd128;
            ay_reg        <= 8'd128;
            btn_reg       <= 8'd0;
            xfer_reg      <= 1'b0;
            remain_reg    <= 8'd0;
            ptr_reg       <= 8'd0;
            wait_out_reg  <= 1'b0;
            imm_cnt_reg   <= 2'd0;
            imm_idx_reg   <= 2'd0;
            bcnt_reg      <= 6'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            addr_reg      <= addr_next;
            idle_reg      <= idle_next;
            prot_reg      <= prot_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            btn_reg       <= btn_next;
            xfer_reg      <= xfer_next;
            remain_reg    <= remain_next;
            ptr_reg       <= ptr_next;
            wait_out_reg  <= wait_out_next;
            imm_cnt_reg   <= imm_cnt_next;
            imm_idx_reg   <= imm_idx_next;
            bcnt_reg      <= bcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        imm_rsp_reg  <= imm_rsp_next;
        imm_byte_reg <= imm_byte_next;
        res_reg      <= res_next;
    end

    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_WR)
        else $error("rom read not followed by load");

    a_imm_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IMM |-> imm_idx_reg < imm_cnt_reg)
        else $error("immediate index past count");

    a_bcnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_WR) |-> bcnt_reg != 6'd0)
        else $error("streaming with zero byte count");

endmodule

>>> hw/rtl/uhid_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhid_rom
// descriptor image, synchronous read registered on rd_en
// ----------------------------------------------------------------------------
module uhid_rom #(
    parameter int ROM_DEPTH   = uhid_pkg::ROM_DEPTH_DEF,
    parameter int PACKET_SIZE = uhid_pkg::PACKET_SIZE_DEF,
    localparam int AW         = $clog2(ROM_DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [ROM_DEPTH];
    logic [7:0] rd_data_reg;

    always_comb
    begin
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            mem[i] = uhid_pkg::rom_byte(9'(i), 8'(PACKET_SIZE));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
